/* design/cda_pkg.sv */
`default_nettype none

package cda_pkg;

  typedef logic [1:0]  kind_t;
  typedef logic [13:0] year_t;
  typedef logic [3:0]  month_t;
  typedef logic [4:0]  day_t;

  localparam kind_t KIND_SET    = 2'd0;
  localparam kind_t KIND_DAYS   = 2'd1;
  localparam kind_t KIND_MONTHS = 2'd2;
  localparam kind_t KIND_YEARS  = 2'd3;

  localparam int AMOUNT_WIDTH_DEF = 12;

  localparam year_t  MAX_YEAR  = 14'd9999;
  localparam month_t MONTH_JAN = 4'd1;
  localparam month_t MONTH_FEB = 4'd2;
  localparam month_t MONTH_DEC = 4'd12;
  localparam day_t   DAY_FIRST = 5'd1;

  // floor(y / 100) = (y * 5243) >> 19, exact for any 14-bit year in range
  localparam int DIV100_MUL   = 5243;
  localparam int DIV100_SHIFT = 19;
  // floor(t / 3) = (t * 43691) >> 17, exact for t below 2**17
  localparam int DIV3_MUL     = 43691;
  localparam int DIV3_SHIFT   = 17;

  function automatic day_t month_len(input month_t m, input logic leap);
    day_t len;
    begin
      len = 5'd31;
      case (m)
        4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
        MONTH_FEB:               len = leap ? 5'd29 : 5'd28;
        default:                 len = 5'd31;
      endcase
      return len;
    end
  endfunction

endpackage

`default_nettype wire

/* design/calendar_date_adder.sv */
`default_nettype none

// Gregorian date register with add operations.
// Input channel (in_valid / in_stall): one transaction carries a kind and
// its operands. Set loads a date (year saturated at 9999, month clamped to
// 1..12, day 0 taken as 1). Add days, add months and add years move the
// stored date forward by in_amount.
// Result channel (out_valid / out_stall): one transaction per input, giving
// the date after the operation and an overflow flag. On overflow (year would
// pass 9999) the stored date is left as it was and is returned unchanged.
// Path from accept to the result: set and add years go straight to the done
// state; add months pass the divide and finish states; add days pass a
// prepare state, then walk month by month (about 135 months for 4095 days)
// through a single compare/subtract unit. in_stall is high from accept until
// the result is loaded into the output register, so one transaction is in
// flight at a time and the next is taken only after that load.
// A stalled result sits in the output register while the next input is
// taken; a finished transaction waits until the register is free.
// Reset: date becomes 0001-01-01, no result pending.
module calendar_date_adder #(
  parameter int AMOUNT_WIDTH = cda_pkg::AMOUNT_WIDTH_DEF
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  wire cda_pkg::kind_t     in_kind,
  input  wire cda_pkg::year_t     in_set_year,
  input  wire cda_pkg::month_t    in_set_month,
  input  wire cda_pkg::day_t      in_set_day,
  input  wire [AMOUNT_WIDTH-1:0]  in_amount,
  output logic                    out_valid,
  input  wire                     out_stall,
  output cda_pkg::year_t          out_year,
  output cda_pkg::month_t         out_month,
  output cda_pkg::day_t           out_day,
  output logic                    out_overflow
);
  import cda_pkg::*;

  // working day count: day plus amount before the walk
  localparam int DW = ((AMOUNT_WIDTH > 5) ? AMOUNT_WIDTH : 5) + 1;
  // months since January of the current year plus amount
  localparam int TW = AMOUNT_WIDTH + 1;
  localparam int PW = TW + 16;
  localparam int SW = ((TW > 14) ? TW : 14) + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_WALK = 3'd2;
  localparam logic [2:0] S_MDIV = 3'd3;
  localparam logic [2:0] S_MFIN = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]    state_r, state_nxt;
  year_t         cur_year_r, cur_year_nxt;
  month_t        cur_month_r, cur_month_nxt;
  day_t          cur_day_r, cur_day_nxt;
  year_t         wy_r, wy_nxt;
  month_t        wm_r, wm_nxt;
  logic [DW-1:0] wd_r, wd_nxt;
  logic          ovf_r, ovf_nxt;
  logic [TW-1:0] total_r, total_nxt;
  logic [TW-1:0] quot_r, quot_nxt;
  logic          out_valid_r, out_valid_nxt;
  year_t         out_year_r, out_year_nxt;
  month_t        out_month_r, out_month_nxt;
  day_t          out_day_r, out_day_nxt;
  logic          out_ovf_r, out_ovf_nxt;

  logic          accept;
  logic          out_free;
  logic          leap;
  day_t          len;
  logic          fits;
  logic [DW-1:0] diff;
  logic [SW-1:0] add_a, add_b, ysum;
  logic          add_over;
  logic [TW-1:0] total_in;
  logic [PW-1:0] prod;
  logic [TW-1:0] rem_full;
  month_t        rem;
  year_t         set_y;
  month_t        set_m;
  day_t          set_d;

  cda_leap u_leap (
    .clk  (clk),
    .year (wy_r),
    .leap (leap)
  );

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // single compare/subtract for the month walk
  assign len  = month_len(wm_r, leap);
  assign fits = (wd_r <= DW'(len));
  assign diff = wd_r - DW'(len);

  // shared year adder: amount of years at accept, carried years at finish
  assign add_a    = (state_r == S_MFIN) ? SW'(wy_r) : SW'(cur_year_r);
  assign add_b    = (state_r == S_MFIN) ? SW'(quot_r) : SW'(in_amount);
  assign ysum     = add_a + add_b;
  assign add_over = (ysum > SW'(MAX_YEAR));

  // month carry: total / 12 = (total >> 2) / 3
  assign total_in = TW'(cur_month_r) - TW'(1) + TW'(in_amount);
  assign prod     = PW'(total_r >> 2) * PW'(DIV3_MUL);
  assign rem_full = total_r - (quot_r << 3) - (quot_r << 2);
  assign rem      = rem_full[3:0];

  assign set_y = (in_set_year > MAX_YEAR) ? MAX_YEAR : in_set_year;
  assign set_m = (in_set_month == 4'd0) ? MONTH_JAN :
                 ((in_set_month > MONTH_DEC) ? MONTH_DEC : in_set_month);
  assign set_d = (in_set_day == 5'd0) ? DAY_FIRST : in_set_day;

  always_comb begin
    state_nxt     = state_r;
    cur_year_nxt  = cur_year_r;
    cur_month_nxt = cur_month_r;
    cur_day_nxt   = cur_day_r;
    wy_nxt        = wy_r;
    wm_nxt        = wm_r;
    wd_nxt        = wd_r;
    ovf_nxt       = ovf_r;
    total_nxt     = total_r;
    quot_nxt      = quot_r;
    out_valid_nxt = out_valid_r;
    out_year_nxt  = out_year_r;
    out_month_nxt = out_month_r;
    out_day_nxt   = out_day_r;
    out_ovf_nxt   = out_ovf_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          ovf_nxt = 1'b0;
          wy_nxt  = cur_year_r;
          wm_nxt  = cur_month_r;
          wd_nxt  = DW'(cur_day_r);
          case (in_kind)
            KIND_SET: begin
              wy_nxt    = set_y;
              wm_nxt    = set_m;
              wd_nxt    = DW'(set_d);
              state_nxt = S_DONE;
            end
            KIND_DAYS: begin
              wd_nxt    = DW'(cur_day_r) + DW'(in_amount);
              state_nxt = S_PREP;
            end
            KIND_MONTHS: begin
              total_nxt = total_in;
              state_nxt = S_MDIV;
            end
            default: begin
              if (add_over) begin
                ovf_nxt = 1'b1;
              end else begin
                wy_nxt = ysum[13:0];
              end
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      // leap flag settles on the loaded year
      S_PREP: begin
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (fits) begin
          state_nxt = S_DONE;
        end else begin
          wd_nxt = diff;
          if (wm_r == MONTH_DEC) begin
            if (wy_r == MAX_YEAR) begin
              ovf_nxt   = 1'b1;
              state_nxt = S_DONE;
            end else begin
              wm_nxt = MONTH_JAN;
              wy_nxt = wy_r + 14'd1;
            end
          end else begin
            wm_nxt = wm_r + 4'd1;
          end
        end
      end
      S_MDIV: begin
        quot_nxt  = TW'(prod >> DIV3_SHIFT);
        state_nxt = S_MFIN;
      end
      S_MFIN: begin
        if (add_over) begin
          ovf_nxt = 1'b1;
        end else begin
          wy_nxt = ysum[13:0];
          wm_nxt = rem + 4'd1;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ovf_nxt   = ovf_r;
          if (ovf_r) begin
            out_year_nxt  = cur_year_r;
            out_month_nxt = cur_month_r;
            out_day_nxt   = cur_day_r;
          end else begin
            cur_year_nxt  = wy_r;
            cur_month_nxt = wm_r;
            cur_day_nxt   = wd_r[4:0];
            out_year_nxt  = wy_r;
            out_month_nxt = wm_r;
            out_day_nxt   = wd_r[4:0];
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_year_r  <= 14'd1;
      cur_month_r <= MONTH_JAN;
      cur_day_r   <= DAY_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_year_r  <= cur_year_nxt;
      cur_month_r <= cur_month_nxt;
      cur_day_r   <= cur_day_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wy_r        <= wy_nxt;
    wm_r        <= wm_nxt;
    wd_r        <= wd_nxt;
    ovf_r       <= ovf_nxt;
    total_r     <= total_nxt;
    quot_r      <= quot_nxt;
    out_year_r  <= out_year_nxt;
    out_month_r <= out_month_nxt;
    out_day_r   <= out_day_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_year     = out_year_r;
  assign out_month    = out_month_r;
  assign out_day      = out_day_r;
  assign out_overflow = out_ovf_r;

endmodule

`default_nettype wire

/* design/cda_leap.sv */
`default_nettype none

// Leap-year flag for the working year; quotient by 100 registered, so after a
// year change the flag is valid from the next cycle.
module cda_leap (
  input  wire                 clk,
  input  wire cda_pkg::year_t year,
  output logic                leap
);
  import cda_pkg::*;

  localparam int PW = 27;

  logic [PW-1:0] prod;
  logic [6:0]    cent_r;
  logic [6:0]    cent_nxt;
  year_t         hundreds;

  assign prod     = PW'(year) * PW'(DIV100_MUL);
  assign cent_nxt = 7'(prod >> DIV100_SHIFT);

  always_ff @(posedge clk) begin
    cent_r <= cent_nxt;
  end

  assign hundreds = (14'(cent_r) << 6) + (14'(cent_r) << 5) + (14'(cent_r) << 2);
  assign leap     = (year[1:0] == 2'b00) &&
                    ((year != hundreds) || (cent_r[1:0] == 2'b00));

endmodule

`default_nettype wire
